// ===== rtl/grt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grt_pkg
// Shared codes, widths and types of the gamepad receive tracker.
// ----------------------------------------------------------------------------
package grt_pkg;

  // Field widths on the ports
  localparam int CMD_W = 8;
  localparam int SEQ_W = 8;
  localparam int LEN_W = 28;
  localparam int ST_W  = 2;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int COMMAND_COUNT_DEF = 256;
  localparam int LENGTH_BITS_DEF   = 28;

  // Packed stream widths (data in whole bytes)
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_ACCEPT  = 2'd0;
  localparam logic [ST_W-1:0] ST_PENDING = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
  localparam logic [ST_W-1:0] ST_DUP     = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_CMD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESC_CMD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWERED_ON  = 2'd2;

  // Configuration reset values
  localparam logic [CMD_W-1:0] ARRIVAL_CMD_RST = 8'd2;
  localparam logic [CMD_W-1:0] DESC_CMD_RST    = 8'd4;

  // Descriptor failure counter saturates here
  localparam logic [1:0] FAIL_LIMIT = 2'd3;

  // Chunk tracker verdict for the item in the compute stage
  typedef struct packed {
    logic [ST_W-1:0]  status;      // accept, pending or invalid
    logic [LEN_W-1:0] accept_len;  // payload length, or total on sequence close
    logic [LEN_W-1:0] ack_bytes;
    logic [LEN_W-1:0] ack_rem;
    logic             chunk_open;  // sequence currently open (registered)
  } grt_chk_t;

endpackage

// ===== rtl/grt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module grt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read-first: a same-edge write is not seen by the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/grt_chunk_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grt_chunk_tracker
// Chunk reassembly state and per-item start/alignment/bounds/end checks.
// ----------------------------------------------------------------------------
module grt_chunk_tracker #(
  parameter int LENGTH_BITS = grt_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,        // item leaves the compute stage
  input  logic                   is_chunked,
  input  logic                   chunk_start,
  input  logic                   needs_ack,
  input  logic [LENGTH_BITS-1:0] plen,
  input  logic [LENGTH_BITS-1:0] offs,
  output grt_pkg::grt_chk_t      chk
);
  import grt_pkg::*;

  logic                   open_r, open_nxt;
  logic [LENGTH_BITS-1:0] total_r, total_nxt;
  logic [LENGTH_BITS-1:0] bytes_r, bytes_nxt;

  logic                   start_path;
  logic [LENGTH_BITS-1:0] pos;
  logic [LENGTH_BITS-1:0] tl_e;
  logic [LENGTH_BITS-1:0] br_e;
  logic [LENGTH_BITS:0]   sum;
  logic                   closing;
  logic [ST_W-1:0]        status;

  // A start chunk (or any chunk with no open sequence) restarts the window
  assign start_path = !open_r || chunk_start;
  assign pos  = start_path ? '0 : offs;
  assign tl_e = start_path ? offs : total_r;
  assign br_e = start_path ? '0 : bytes_r;
  assign sum  = {1'b0, pos} + {1'b0, plen};

  // Check sequence
  always_comb begin
    open_nxt  = open_r;
    total_nxt = total_r;
    bytes_nxt = bytes_r;
    closing   = 1'b0;
    status    = ST_ACCEPT;
    if (is_chunked && offs != '0) begin
      if (!open_r && !chunk_start) begin
        status = ST_INVALID;
      end else begin
        // opening is committed even if a later check fails
        if (start_path) begin
          open_nxt  = 1'b1;
          total_nxt = offs;
          bytes_nxt = '0;
        end
        if (pos != br_e) begin
          status = ST_INVALID;
        end else if (pos >= tl_e) begin
          if (pos > tl_e || plen != '0) begin
            status = ST_INVALID;
          end else begin
            open_nxt  = 1'b0;
            bytes_nxt = '0;
            closing   = 1'b1;
          end
        end else if (sum > {1'b0, tl_e}) begin
          status = ST_INVALID;
        end else begin
          bytes_nxt = sum[LENGTH_BITS-1:0];
          status    = ST_PENDING;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      total_r <= '0;
      bytes_r <= '0;
    end else if (fire) begin
      open_r  <= open_nxt;
      total_r <= total_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  // Verdict and acknowledge fields, from state before this item
  always_comb begin
    chk.status     = status;
    chk.accept_len = closing ? LEN_W'(total_r) : LEN_W'(plen);
    chk.ack_bytes  = '0;
    chk.ack_rem    = '0;
    chk.chunk_open = open_r;
    if (needs_ack) begin
      if (is_chunked) begin
        chk.ack_bytes = LEN_W'(bytes_r);
        chk.ack_rem   = LEN_W'(total_r - bytes_r);
      end else begin
        chk.ack_bytes = LEN_W'(plen);
      end
    end
  end

endmodule

// ===== rtl/grt_seq_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grt_seq_filter
// Per-command last-sequence table with valid bits and write bypass.
// ----------------------------------------------------------------------------
module grt_seq_filter #(
  parameter int COMMAND_COUNT = grt_pkg::COMMAND_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,     // item enters the compute stage
  input  logic [grt_pkg::CMD_W-1:0] rd_cmd,
  input  logic                     wr_en,     // compute-stage item updates its entry
  input  logic [grt_pkg::SEQ_W-1:0] wr_seq,
  output logic [grt_pkg::SEQ_W-1:0] last_seq  // entry of the compute-stage item
);
  import grt_pkg::*;

  localparam int SLOT_W   = $clog2(COMMAND_COUNT);
  localparam int CMD_CODES = 1 << CMD_W;

  // Command to table slot, worked out at elaboration
  logic [SLOT_W-1:0] slot_lut [CMD_CODES];
  for (genvar i = 0; i < CMD_CODES; i++) begin : g_slot
    assign slot_lut[i] = SLOT_W'(i % COMMAND_COUNT);
  end

  logic [SLOT_W-1:0]      rd_slot;
  logic [SLOT_W-1:0]      slot_r;
  logic [COMMAND_COUNT-1:0] valid_r;
  logic                   fwd_hit_r;
  logic [SEQ_W-1:0]       fwd_data_r;
  logic [SEQ_W-1:0]       ram_q;

  assign rd_slot = slot_lut[rd_cmd];

  grt_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (COMMAND_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_seq),
    .rd_en   (rd_en),
    .rd_addr (rd_slot),
    .rd_data (ram_q)
  );

  // Slot of the next item, and bypass of a write landing on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (rd_slot == slot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      slot_r     <= rd_slot;
      fwd_data_r <= wr_seq;
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[slot_r] <= 1'b1;
    end
  end

  assign last_seq = fwd_hit_r ? fwd_data_r :
                    (valid_r[slot_r] ? ram_q : '0);

endmodule

// ===== rtl/gip_receive_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gip_receive_tracker_top
// Chunked message receive tracker for decoded gamepad-protocol headers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one decoded header per item. in_tdata carries command, sequence,
//           needs_ack, payload length and chunk offset; in_tuser carries the
//           is_chunked and chunk_start flags.
//   out_* : one result per header: status in out_tuser, length, acknowledge
//           fields and request flags in out_tdata.
//   cfg_* : register writes, one per cycle with cfg_we, only while idle (the
//           user's rule; the block itself does not enforce it).
// Throughput is one item per cycle while the output drains. An item taken
// sits in the compute register; its result is loaded into the output
// register once that is free, which raises out_tvalid. The per-item cost
// is one compare/add stage against the chunk state plus one read of the
// sequence table RAM, whose address is issued as the item is accepted.
// When out_tready is low the result holds, one more item can be taken into
// the compute register, then in_tready drops until the output drains.
// Synchronous reset clears the chunk state, the failure counter and the table
// valid bits, and returns the config registers to their defaults; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module gip_receive_tracker_top #(
  parameter int COMMAND_COUNT = grt_pkg::COMMAND_COUNT_DEF,
  parameter int LENGTH_BITS   = grt_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command[7:0], sequence_req[15:8], needs_ack[16], payload_length[44:17],
  // byte_offset[72:45], zero fill above
  input  logic [grt_pkg::IN_DATA_W-1:0]   in_tdata,
  // is_chunked[0], chunk_start[1]
  input  logic [grt_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // message_length[27:0], ack_send[28], ack_bytes[56:29], ack_remaining[84:57],
  // request_descriptor[85], request_power_on[86], descriptor_failed[87]
  output logic [grt_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[1:0]
  output logic [grt_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [grt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [grt_pkg::CFG_W-1:0]       cfg_wdata
);
  import grt_pkg::*;

  // Configuration registers
  logic [CMD_W-1:0] arrival_cmd_r;
  logic [CMD_W-1:0] desc_cmd_r;
  logic             powered_on_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_cmd_r <= ARRIVAL_CMD_RST;
      desc_cmd_r    <= DESC_CMD_RST;
      powered_on_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ARRIVAL_CMD: arrival_cmd_r <= cfg_wdata;
        CFG_DESC_CMD:    desc_cmd_r    <= cfg_wdata;
        CFG_POWERED_ON:  powered_on_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake: compute register advances when the output register is free
  logic s1_valid_r;
  logic s1_adv;
  logic s1_fire;
  logic in_fire;

  assign s1_adv    = !out_tvalid || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // Compute (input) register
  logic [CMD_W-1:0] cmd_r;
  logic [SEQ_W-1:0] seq_r;
  logic             ack_r;
  logic             chunked_r;
  logic             start_r;
  logic [LEN_W-1:0] plen_r;
  logic [LEN_W-1:0] offs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= in_tdata[7:0];
      seq_r     <= in_tdata[15:8];
      ack_r     <= in_tdata[16];
      plen_r    <= in_tdata[44:17];
      offs_r    <= in_tdata[72:45];
      chunked_r <= in_tuser[0];
      start_r   <= in_tuser[1];
    end
  end

  // Chunk checks
  grt_chk_t chk;

  grt_chunk_tracker #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_chunk (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .is_chunked  (chunked_r),
    .chunk_start (start_r),
    .needs_ack   (ack_r),
    .plen        (plen_r[LENGTH_BITS-1:0]),
    .offs        (offs_r[LENGTH_BITS-1:0]),
    .chk         (chk)
  );

  // Duplicate filter
  logic [SEQ_W-1:0] last_seq;
  logic             is_accept;
  logic             is_invalid;
  logic             is_dup;
  logic             fresh;
  logic             tbl_we;

  assign is_accept  = (chk.status == ST_ACCEPT);
  assign is_invalid = (chk.status == ST_INVALID);
  assign is_dup     = is_accept && (seq_r == last_seq);
  assign fresh      = is_accept && !is_dup;
  assign tbl_we     = s1_fire && fresh;

  grt_seq_filter #(
    .COMMAND_COUNT (COMMAND_COUNT)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_cmd   (in_tdata[7:0]),
    .wr_en    (tbl_we),
    .wr_seq   (seq_r),
    .last_seq (last_seq)
  );

  // Descriptor failure counter, saturating
  logic [1:0] fail_cnt_r;
  logic       desc_invalid;

  assign desc_invalid = is_invalid && (cmd_r == desc_cmd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_cnt_r <= '0;
    end else if (s1_fire && desc_invalid && fail_cnt_r < FAIL_LIMIT) begin
      fail_cnt_r <= fail_cnt_r + 2'd1;
    end
  end

  // Result assembly
  logic [ST_W-1:0]  status_c;
  logic [LEN_W-1:0] msg_len_c;
  logic             req_desc_c;
  logic             req_pow_c;
  logic             desc_fail_c;

  assign status_c    = is_dup ? ST_DUP : chk.status;
  assign msg_len_c   = is_accept ? chk.accept_len : '0;
  assign req_desc_c  = fresh && (cmd_r == arrival_cmd_r);
  assign req_pow_c   = fresh && (cmd_r == desc_cmd_r) && !powered_on_r;
  // after this item the count is at the limit
  assign desc_fail_c = desc_invalid && (fail_cnt_r >= FAIL_LIMIT - 2'd1);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (s1_adv) begin
      out_tvalid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_tuser <= status_c;
      out_tdata <= {desc_fail_c, req_pow_c, req_desc_c, chk.ack_rem,
                    chk.ack_bytes, ack_r, msg_len_c};
    end
  end

  // Assertions
  a_pending_opens: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && chk.status == ST_PENDING |=> chk.chunk_open)
    else $error("pending chunk did not leave a sequence open");

  a_fail_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> fail_cnt_r >= $past(fail_cnt_r))
    else $error("descriptor failure count decreased");

  a_fail_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && desc_fail_c |=> fail_cnt_r == FAIL_LIMIT)
    else $error("descriptor failure flagged below the limit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule
